/* rtl/schaff_trend_cycle_top_defines.svh */
// Assertion macros for the trend cycle block.
`ifndef SCHAFF_TREND_CYCLE_TOP_DEFINES_SVH
`define SCHAFF_TREND_CYCLE_TOP_DEFINES_SVH

// Implication checked every cycle outside reset.
`define STC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("trend cycle check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define STC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("trend cycle check failed");

`endif

/* rtl/stc_pkg.sv */
`timescale 1ns / 1ps
package stc_pkg;
    localparam int MAX_WINDOW = 64;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 7;
    localparam int W_W        = 17;
    localparam int PRICE_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int STC_W      = 23;
    localparam int VAL_W      = 34;
    localparam int NUM_W      = 57;
    localparam logic [W_W-1:0]   ONE_Q16     = 17'd65536;
    localparam logic [STC_W-1:0] HUNDRED_Q16 = 23'd6553600;

    localparam logic [1:0] TREND_FIRST = 2'd0;
    localparam logic [1:0] TREND_RISE  = 2'd1;
    localparam logic [1:0] TREND_FALL  = 2'd2;

    typedef enum logic [1:0] {
        CFG_WINDOW = 2'd0,
        CFG_FAST   = 2'd1,
        CFG_SLOW   = 2'd2,
        CFG_SMOOTH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic shift_diff;
        logic shift_sm;
        logic rotate;
    } cell_ctrl_t;

    // cur + floor(w * (tgt - cur) / 65536)
    function automatic logic signed [VAL_W-1:0] approach(
        input logic signed [VAL_W-1:0] cur,
        input logic signed [VAL_W-1:0] tgt,
        input logic [W_W-1:0] w
    );
        logic signed [VAL_W:0] d;
        logic signed [VAL_W+W_W+1:0] p;
        logic signed [VAL_W+W_W+1:0] q;
        d = {tgt[VAL_W-1], tgt} - {cur[VAL_W-1], cur};
        p = d * $signed({1'b0, w});
        q = p >>> 16;
        return cur + q[VAL_W-1:0];
    endfunction
endpackage

/* rtl/stc_cell.sv */
`timescale 1ns / 1ps
module stc_cell (
    input  logic                                 aclk,
    input  stc_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [stc_pkg::DIFF_W-1:0]    diff_in,
    input  logic        [stc_pkg::STC_W-1:0]     sm_in,
    output logic signed [stc_pkg::DIFF_W-1:0]    diff_out,
    output logic        [stc_pkg::STC_W-1:0]     sm_out
);
    logic signed [stc_pkg::DIFF_W-1:0] diff_reg;
    logic        [stc_pkg::STC_W-1:0]  sm_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.rotate || ctrl.shift_diff) begin
            diff_reg <= diff_in;
        end
        if (ctrl.rotate || ctrl.shift_sm) begin
            sm_reg <= sm_in;
        end
    end

    assign diff_out = diff_reg;
    assign sm_out   = sm_reg;
endmodule

/* rtl/stc_divider.sv */
`timescale 1ns / 1ps
module stc_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [stc_pkg::NUM_W-1:0]    num,
    input  logic [stc_pkg::VAL_W-1:0]    den,
    output logic                         busy,
    output logic                         done,
    output logic [stc_pkg::STC_W-1:0]    quo
);
    localparam int CNT_W = $clog2(stc_pkg::NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(stc_pkg::NUM_W - 1);

    logic [stc_pkg::VAL_W:0]     rem_reg;
    logic [stc_pkg::NUM_W-1:0]   dvd_reg;
    logic [stc_pkg::VAL_W-1:0]   den_reg;
    logic [stc_pkg::STC_W-1:0]   quo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg, done_reg;
    logic [stc_pkg::VAL_W:0]     trial;
    logic                        fits;

    assign trial = {rem_reg[stc_pkg::VAL_W-1:0], dvd_reg[stc_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= num;
                den_reg  <= den;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? trial - {1'b0, den_reg} : trial;
                dvd_reg <= {dvd_reg[stc_pkg::NUM_W-2:0], 1'b0};
                quo_reg <= {quo_reg[stc_pkg::STC_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

/* rtl/schaff_trend_cycle_top.sv */
`timescale 1ns / 1ps
// Schaff trend cycle: one price beat in, one result beat out. The next input
// beat is taken in the cycle after the result beat goes valid at the earliest.
// Each item passes through the two averages, a rotation of the history chain
// for each of the two rolling min/max scans (every history entry lives in one
// cell of a 64-cell chain that rotates past a compare tap), and a division for
// each quotient that is not held (start, 57 shift-subtract steps, done). The
// input takes a new beat only when the previous item is done; a finished
// result stays on the master side until it is taken. No clearing pass is
// needed after reset.
`include "schaff_trend_cycle_top_defines.svh"
module schaff_trend_cycle_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] price
    input  logic [0:0]  s_tuser,   // [0] series_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [22:0] stc_value, [23] zero
    output logic [1:0]  m_tuser,   // [1:0] trend
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);
    localparam int N = stc_pkg::MAX_WINDOW;
    localparam int VW = stc_pkg::VAL_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FAST, ST_SLOW, ST_PUSH, ST_SCAN, ST_CHECK,
        ST_MUL, ST_DIV, ST_SMOOTH, ST_STORE, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [stc_pkg::LEN_W-1:0] wl_reg;
    logic [stc_pkg::W_W-1:0]   fa_reg, sa_reg, sf_reg;
    logic [stc_pkg::LEN_W-1:0] len;
    logic [stc_pkg::W_W-1:0]   fa_w, sa_w, sf_w;

    // item state
    logic signed [VW-1:0]          x_reg, fast_reg, slow_reg, lo_reg, hi_reg, scan_x_reg;
    logic [stc_pkg::STC_W-1:0]     fstoch_reg, fs_reg, sstoch_reg, prev_reg;
    logic [stc_pkg::LEN_W-1:0]     count_reg;
    logic [stc_pkg::SLOT_W-1:0]    k_reg;
    logic                          first_reg, pass_reg;
    logic [stc_pkg::NUM_W-1:0]     num_reg;
    logic                          div_start_reg;

    // chain
    stc_pkg::cell_ctrl_t               ctrl;
    logic signed [stc_pkg::DIFF_W-1:0] diff_chain [N];
    logic        [stc_pkg::STC_W-1:0]  sm_chain [N];
    logic signed [stc_pkg::DIFF_W-1:0] diff_head;
    logic        [stc_pkg::STC_W-1:0]  sm_head;
    logic signed [stc_pkg::DIFF_W-1:0] new_diff;

    // divider
    logic                          div_busy, div_done;
    logic [stc_pkg::STC_W-1:0]     div_quo;

    // misc combinational
    logic signed [VW-1:0]          tap, range, x_lo, stc_full;
    logic [stc_pkg::SLOT_W-1:0]    age;
    logic                          take;
    logic                          hold;

    assign len  = (wl_reg == '0) ? stc_pkg::LEN_W'(1) :
                  (wl_reg > stc_pkg::LEN_W'(N)) ? stc_pkg::LEN_W'(N) : wl_reg;
    assign fa_w = (fa_reg > stc_pkg::ONE_Q16) ? stc_pkg::ONE_Q16 : fa_reg;
    assign sa_w = (sa_reg > stc_pkg::ONE_Q16) ? stc_pkg::ONE_Q16 : sa_reg;
    assign sf_w = (sf_reg > stc_pkg::ONE_Q16) ? stc_pkg::ONE_Q16 : sf_reg;

    assign new_diff = fast_reg[stc_pkg::DIFF_W-1:0] - slow_reg[stc_pkg::DIFF_W-1:0];

    // cell 0 takes the new value on a shift and the tail on a rotation
    assign diff_head = ctrl.rotate ? diff_chain[N-1] : new_diff;
    assign sm_head   = ctrl.rotate ? sm_chain[N-1]   : fs_reg;

    always_comb begin
        ctrl = '0;
        ctrl.shift_diff = (state_reg == ST_PUSH);
        ctrl.shift_sm   = (state_reg == ST_STORE);
        ctrl.rotate     = (state_reg == ST_SCAN);
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_head
            stc_cell u_cell (
                .aclk(aclk), .ctrl(ctrl), .diff_in(diff_head), .sm_in(sm_head),
                .diff_out(diff_chain[i]), .sm_out(sm_chain[i])
            );
        end else begin : g_body
            stc_cell u_cell (
                .aclk(aclk), .ctrl(ctrl), .diff_in(diff_chain[i-1]), .sm_in(sm_chain[i-1]),
                .diff_out(diff_chain[i]), .sm_out(sm_chain[i])
            );
        end
    end

    stc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(num_reg), .den(range[VW-1:0]),
        .busy(div_busy), .done(div_done), .quo(div_quo)
    );

    // after k rotations the head cell holds the entry of age -k mod N
    assign age  = -k_reg;
    assign take = (k_reg == '0) || ({1'b0, age} < len);
    assign tap  = pass_reg ? VW'($signed({1'b0, sm_chain[0]}))
                           : VW'(diff_chain[0]);
    assign range = hi_reg - lo_reg;
    assign x_lo  = scan_x_reg - lo_reg;
    assign hold  = (count_reg < len) || (range <= 0);
    assign stc_full = stc_pkg::approach(VW'($signed({1'b0, prev_reg})),
                                        VW'($signed({1'b0, sstoch_reg})), sf_w);

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wl_reg        <= 7'd10;
            fa_reg        <= 17'd5461;
            sa_reg        <= 17'd2570;
            sf_reg        <= 17'd32768;
            count_reg     <= '0;
            fstoch_reg    <= '0;
            fs_reg        <= '0;
            sstoch_reg    <= '0;
            prev_reg      <= '0;
            m_tvalid      <= 1'b0;
            div_start_reg <= 1'b0;
            pass_reg      <= 1'b0;
            k_reg         <= '0;
        end else begin
            // pulse the divider start while the product is loaded
            div_start_reg <= (state_reg == ST_MUL);
            if (cfg_wr_en) begin
                case (stc_pkg::cfg_idx_t'(cfg_index))
                    stc_pkg::CFG_WINDOW: wl_reg <= cfg_wdata[stc_pkg::LEN_W-1:0];
                    stc_pkg::CFG_FAST:   fa_reg <= cfg_wdata;
                    stc_pkg::CFG_SLOW:   sa_reg <= cfg_wdata;
                    stc_pkg::CFG_SMOOTH: sf_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // a new result loads in ST_OUT, so drop valid here only otherwise
            if (m_tvalid && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        x_reg     <= VW'($signed(s_tdata));
                        first_reg <= s_tuser[0] || (count_reg == '0);
                        // series start: clear the count, stochastic and previous-result registers
                        if (s_tuser[0]) begin
                            count_reg  <= '0;
                            fstoch_reg <= '0;
                            fs_reg     <= '0;
                            sstoch_reg <= '0;
                            prev_reg   <= '0;
                        end
                        state_reg <= ST_FAST;
                    end
                end
                ST_FAST: begin
                    fast_reg  <= first_reg ? x_reg : stc_pkg::approach(fast_reg, x_reg, fa_w);
                    state_reg <= ST_SLOW;
                end
                ST_SLOW: begin
                    slow_reg  <= first_reg ? x_reg : stc_pkg::approach(slow_reg, x_reg, sa_w);
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    // shift the new difference into the chain, seed the scan
                    if (count_reg < stc_pkg::LEN_W'(N)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    scan_x_reg <= VW'(new_diff);
                    lo_reg     <= VW'(new_diff);
                    hi_reg     <= VW'(new_diff);
                    pass_reg   <= 1'b0;
                    k_reg      <= '0;
                    state_reg  <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (take) begin
                        if (tap < lo_reg) lo_reg <= tap;
                        if (tap > hi_reg) hi_reg <= tap;
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == stc_pkg::SLOT_W'(N - 1)) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (hold) begin
                        state_reg <= pass_reg ? ST_OUT : ST_SMOOTH;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    num_reg       <= stc_pkg::NUM_W'(x_lo[VW-1:0]) *
                                     stc_pkg::NUM_W'(stc_pkg::HUNDRED_Q16);
                    state_reg     <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (pass_reg) begin
                            sstoch_reg <= div_quo;
                            state_reg  <= ST_OUT;
                        end else begin
                            fstoch_reg <= div_quo;
                            state_reg  <= ST_SMOOTH;
                        end
                    end
                end
                ST_SMOOTH: begin
                    fs_reg <= stc_pkg::STC_W'(stc_pkg::approach(
                        VW'($signed({1'b0, fs_reg})),
                        VW'($signed({1'b0, fstoch_reg})), sf_w));
                    state_reg <= ST_STORE;
                end
                ST_STORE: begin
                    // shift the smoothed value in, seed the second scan
                    scan_x_reg <= VW'($signed({1'b0, fs_reg}));
                    lo_reg     <= VW'($signed({1'b0, fs_reg}));
                    hi_reg     <= VW'($signed({1'b0, fs_reg}));
                    pass_reg   <= 1'b1;
                    k_reg      <= '0;
                    state_reg  <= ST_SCAN;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!m_tvalid || m_tready) begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= {1'b0, stc_full[stc_pkg::STC_W-1:0]};
                        if (first_reg) begin
                            m_tuser <= stc_pkg::TREND_FIRST;
                        end else if (stc_full[stc_pkg::STC_W-1:0] > prev_reg) begin
                            m_tuser <= stc_pkg::TREND_RISE;
                        end else begin
                            m_tuser <= stc_pkg::TREND_FALL;
                        end
                        prev_reg  <= stc_full[stc_pkg::STC_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `STC_ASSERT_IMPL(a_first_zero, m_tvalid && (m_tuser == stc_pkg::TREND_FIRST), m_tdata == 24'd0)
    `STC_ASSERT_IMPL(a_out_range, m_tvalid, m_tdata <= 24'd6553600)
    `STC_ASSERT_IMPL(a_div_blocks_input, div_busy, !s_tready && (state_reg == ST_DIV))
    `STC_ASSERT_NEXT(a_scan_len, (state_reg == ST_PUSH) || (state_reg == ST_STORE),
                     (state_reg == ST_SCAN) && (k_reg == '0))
endmodule
